@@ src/bba_pkg.sv @@
// Shared constants, codes and control structs of the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    // Pool geometry
    localparam int BLOCK_BYTES = 32;
    localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int POOL_BLOCKS = 256;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = POOL_BLOCKS / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int BLK_W       = $clog2(POOL_BLOCKS);
    localparam int POS_W       = BIT_W + 1;
    localparam int LVLS        = BIT_W;
    localparam int POOL_BYTES  = POOL_BLOCKS * BLOCK_BYTES;

    // Field widths
    localparam int SIZE_W     = 16;
    localparam int OFF_W      = 14;
    localparam int STATUS_W   = 3;
    localparam int BOFF_W     = 13;
    localparam int CNT_W      = 9;
    localparam int BYTE_W     = 14;
    localparam int NEED_W     = 10;
    localparam int RUN_W      = NEED_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [BYTE_W-1:0] COUNT_MAX     = '1;
    localparam logic [BYTE_W-1:0] RST_MAX_REQ   = BYTE_W'(256);
    localparam logic [BYTE_W-1:0] RST_SHALLOW   = BYTE_W'(64);

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_TOO_LARGE  = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_BAD_PTR    = 3'd3,
        ST_NONE_FREED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ZD_NONE    = 2'd0,
        ZD_SHALLOW = 2'd1,
        ZD_HALF    = 2'd2,
        ZD_ALL     = 2'd3
    } t_zdepth;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_REQ    = 2'd0,
        CFG_ZERO_DEPTH = 2'd1,
        CFG_SHALLOW    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic idle;
        logic load;
        logic start_scan;
        logic scan_step;
        logic rmw_rd;
        logic rmw_wr;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic req_valid;
        logic err;
        logic is_free;
        logic found;
        logic scan_last;
        logic rmw_done;
        logic zero_need;
        logic out_free;
    } t_dp_sts;

endpackage

@@ src/bba_ifs.sv @@
// Request, result and configuration channel interfaces of the allocator.
`timescale 1ns / 1ps

interface bba_req_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [SIZE_W-1:0] req_size;
    logic [OFF_W-1:0]  free_offset;

    modport source (output valid, func, req_size, free_offset, input ready);
    modport sink   (input valid, func, req_size, free_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BOFF_W-1:0]   block_offset;
    logic [CNT_W-1:0]    block_count;
    logic [BYTE_W-1:0]   zero_bytes;
    logic [BYTE_W-1:0]   used_bytes;

    modport source (output valid, status, block_offset, block_count, zero_bytes, used_bytes,
                    input ready);
    modport sink   (input valid, status, block_offset, block_count, zero_bytes, used_bytes,
                    output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/bba_ctrl.sv @@
// Sequencer of the allocator: accept, scan, read-modify-write and result phases.
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                priority if (i_sts.err) begin
                    n_state = S_FIN;
                end else if (i_sts.is_free) begin
                    n_state = S_RMW_RD;
                end else begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                priority if (i_sts.found) begin
                    n_state = i_sts.zero_need ? S_FIN : S_RMW_RD;
                end else if (i_sts.scan_last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_RMW_RD: begin
                o_cmd.rmw_rd = 1'b1;
                n_state      = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.rmw_wr = 1'b1;
                n_state      = i_sts.rmw_done ? S_FIN : S_RMW_RD;
            end
            S_FIN: begin
                // hold until the result register can take the new result
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/bba_datapath.sv @@
// Bitmap memory, run scanner, mark/clear unit, counters and result register.
`timescale 1ns / 1ps

module bba_datapath import bba_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    bba_req_if.sink       i_req,
    bba_cfg_if.sink       i_cfg,
    bba_rsp_if.source     o_rsp
);

    // Configuration
    logic [BYTE_W-1:0] r_max_req;
    t_zdepth           r_zdepth;
    logic [BYTE_W-1:0] r_shallow;

    // Operation context
    t_func             r_func;
    t_status           r_err;
    logic [NEED_W-1:0] r_need;
    logic [NEED_W-1:0] r_need_eff;
    logic [NEED_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_total;
    logic [RUN_W-1:0]  r_carry;
    logic [WORD_AW-1:0] r_eval_word;
    logic [BLK_W-1:0]  r_start_blk;
    logic [WORD_AW-1:0] r_rmw_word;
    logic [BIT_W-1:0]  r_bit;
    logic [BYTE_W-1:0] r_used;

    // Bitmap memory
    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_map_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [WORD_AW-1:0]   rd_addr;
    logic [WORD_BITS-1:0] word_d;

    // Result register
    logic              r_out_vld;
    t_status           r_out_status;
    logic [BOFF_W-1:0] r_out_boff;
    logic [CNT_W-1:0]  r_out_cnt;
    logic [BYTE_W-1:0] r_out_zero;

    // Load decode
    logic [SIZE_W:0]   size_rnd;
    logic [NEED_W-1:0] in_need;
    logic [OFF_W-1:0]  off_blk;
    logic              too_large;
    logic              bad_ptr;

    // Scan
    logic [POS_W-1:0]  kpos [0:LVLS][WORD_BITS];
    logic [RUN_W-1:0]  run_len [WORD_BITS];
    logic [WORD_BITS-1:0] hit;
    logic              found;
    logic [BIT_W-1:0]  hit_idx;
    logic [RUN_W-1:0]  carry_out;
    logic [RUN_W-1:0]  scan_start;
    logic              scan_last;

    // Read-modify-write
    logic [POS_W-1:0]  bit_ext;
    logic [POS_W-1:0]  avail;
    logic [POS_W-1:0]  nset;
    logic [POS_W-1:0]  ffree;
    logic [POS_W-1:0]  lim;
    logic [POS_W-1:0]  rmw_n;
    logic [WORD_BITS-1:0] rmw_mask;
    logic [WORD_BITS-1:0] n_map_word;
    logic              rmw_done;

    // Finish
    logic [BYTE_W:0]   alloc_bytes;
    logic [BYTE_W:0]   used_sum;
    logic [BYTE_W-1:0] free_bytes;
    logic [BYTE_W-1:0] n_used;
    logic [BYTE_W-1:0] n_zero;
    t_status           n_status;
    logic [BOFF_W-1:0] n_boff;
    logic [CNT_W-1:0]  n_cnt;

    assign i_req.ready = i_cmd.idle;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.block_offset = r_out_boff;
    assign o_rsp.block_count  = r_out_cnt;
    assign o_rsp.zero_bytes   = r_out_zero;
    assign o_rsp.used_bytes   = r_used;

    // ---------------------------------------------------------------- decode
    always_comb begin
        size_rnd  = {1'b0, i_req.req_size} + (SIZE_W+1)'(BLOCK_BYTES - 1);
        in_need   = NEED_W'(size_rnd >> BLK_SHIFT);
        too_large = i_req.req_size > SIZE_W'(r_max_req);
        bad_ptr   = i_req.free_offset >= OFF_W'(POOL_BYTES);
        off_blk   = i_req.free_offset >> BLK_SHIFT;
    end

    // ---------------------------------------------------------------- memory
    assign word_d = r_rd_vld ? r_rd_data : '0;

    always_comb begin
        priority if (i_cmd.start_scan) begin
            rd_addr = '0;
        end else if (i_cmd.scan_step) begin
            rd_addr = r_eval_word + WORD_AW'(1);
        end else begin
            rd_addr = r_rmw_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rmw_wr) begin
            r_map[r_rmw_word] <= n_map_word;
        end
        r_rd_data <= r_map[rd_addr];
        r_rd_vld  <= r_map_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
        end else if (i_cmd.rmw_wr) begin
            r_map_vld[r_rmw_word] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- scan
    // Free run ending at each bit: prefix-max of (busy position + 1) over the word.
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            kpos[0][j] = word_d[j] ? POS_W'(j + 1) : '0;
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (j >= (1 << l)) begin
                    kpos[l+1][j] = (kpos[l][j] > kpos[l][j - (1 << l)]) ?
                                   kpos[l][j] : kpos[l][j - (1 << l)];
                end else begin
                    kpos[l+1][j] = kpos[l][j];
                end
            end
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            if (kpos[LVLS][j] == '0) begin
                run_len[j] = r_carry + RUN_W'(j + 1);
            end else begin
                run_len[j] = RUN_W'(j + 1) - RUN_W'(kpos[LVLS][j]);
            end
            hit[j] = run_len[j] >= r_need_eff;
        end
    end

    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                found   = 1'b1;
                hit_idx = BIT_W'(j);
            end
        end
        if (kpos[LVLS][WORD_BITS-1] == '0) begin
            carry_out = r_carry + RUN_W'(WORD_BITS);
        end else begin
            carry_out = RUN_W'(WORD_BITS) - RUN_W'(kpos[LVLS][WORD_BITS-1]);
        end
        scan_start = RUN_W'({r_eval_word, hit_idx}) + RUN_W'(1) - r_need_eff;
        scan_last  = r_eval_word == WORD_AW'(MAP_WORDS - 1);
    end

    // ---------------------------------------------------------------- mark / clear
    always_comb begin
        bit_ext = {1'b0, r_bit};
        avail   = POS_W'(WORD_BITS) - bit_ext;
        nset    = (r_rem < NEED_W'(avail)) ? POS_W'(r_rem) : avail;
        ffree   = POS_W'(WORD_BITS);
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!word_d[j] && (POS_W'(j) >= bit_ext)) begin
                ffree = POS_W'(j);
            end
        end
        lim   = (r_func == FN_ALLOC) ? bit_ext + nset : ffree;
        rmw_n = lim - bit_ext;
        for (int j = 0; j < WORD_BITS; j++) begin
            rmw_mask[j] = (POS_W'(j) >= bit_ext) && (POS_W'(j) < lim);
        end
        n_map_word = (r_func == FN_ALLOC) ? (word_d | rmw_mask) : (word_d & ~rmw_mask);
        if (r_func == FN_ALLOC) begin
            rmw_done = r_rem == NEED_W'(rmw_n);
        end else begin
            // stop at the first free block or at the end of the pool
            rmw_done = (ffree != POS_W'(WORD_BITS)) ||
                       (r_rmw_word == WORD_AW'(MAP_WORDS - 1));
        end
    end

    // ---------------------------------------------------------------- result
    always_comb begin
        alloc_bytes = (BYTE_W+1)'(r_need) << BLK_SHIFT;
        used_sum    = {1'b0, r_used} + alloc_bytes;
        free_bytes  = BYTE_W'(r_total) << BLK_SHIFT;
        unique case (r_zdepth)
            ZD_NONE:    n_zero = '0;
            ZD_SHALLOW: n_zero = (r_shallow < free_bytes) ? r_shallow : free_bytes;
            ZD_HALF:    n_zero = free_bytes >> 1;
            ZD_ALL:     n_zero = free_bytes;
            default:    n_zero = '0;
        endcase
        n_status = r_err;
        n_boff   = '0;
        n_cnt    = '0;
        n_used   = r_used;
        priority if (r_err != ST_OK) begin
            n_zero = '0;
        end else if (r_func == FN_ALLOC) begin
            n_zero = '0;
            n_boff = BOFF_W'(r_start_blk) << BLK_SHIFT;
            n_cnt  = CNT_W'(r_need);
            n_used = (used_sum > (BYTE_W+1)'(COUNT_MAX)) ? COUNT_MAX : used_sum[BYTE_W-1:0];
        end else if (r_total == '0) begin
            n_status = ST_NONE_FREED;
            n_zero   = '0;
        end else begin
            n_cnt  = r_total;
            n_used = (r_used >= free_bytes) ? r_used - free_bytes : '0;
        end
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= RST_MAX_REQ;
            r_zdepth  <= ZD_NONE;
            r_shallow <= RST_SHALLOW;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_MAX_REQ:    r_max_req <= BYTE_W'(i_cfg.data);
                    CFG_ZERO_DEPTH: r_zdepth  <= t_zdepth'(i_cfg.data[1:0]);
                    CFG_SHALLOW:    r_shallow <= BYTE_W'(i_cfg.data);
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_used    <= n_used;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- operation context
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= t_func'(i_req.func);
            r_need     <= in_need;
            r_need_eff <= (in_need == '0) ? NEED_W'(1) : in_need;
            r_rem      <= in_need;
            r_total    <= '0;
            r_rmw_word <= off_blk[BLK_W-1:BIT_W];
            r_bit      <= off_blk[BIT_W-1:0];
            if (t_func'(i_req.func) == FN_ALLOC) begin
                r_err <= too_large ? ST_TOO_LARGE : ST_OK;
            end else begin
                r_err <= bad_ptr ? ST_BAD_PTR : ST_OK;
            end
        end
        if (i_cmd.start_scan) begin
            r_carry     <= '0;
            r_eval_word <= '0;
        end
        if (i_cmd.scan_step) begin
            if (found) begin
                r_start_blk <= scan_start[BLK_W-1:0];
                r_rmw_word  <= scan_start[BLK_W-1:BIT_W];
                r_bit       <= scan_start[BIT_W-1:0];
            end else begin
                r_carry     <= carry_out;
                r_eval_word <= r_eval_word + WORD_AW'(1);
                if (scan_last) begin
                    r_err <= ST_NO_SPACE;
                end
            end
        end
        if (i_cmd.rmw_wr) begin
            r_rem      <= r_rem - NEED_W'(rmw_n);
            r_total    <= r_total + CNT_W'(rmw_n);
            r_rmw_word <= r_rmw_word + WORD_AW'(1);
            r_bit      <= '0;
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_boff   <= n_boff;
            r_out_cnt    <= n_cnt;
            r_out_zero   <= n_zero;
        end
    end

    // ---------------------------------------------------------------- status
    always_comb begin
        o_sts.req_valid = i_req.valid;
        o_sts.err       = r_err != ST_OK;
        o_sts.is_free   = r_func == FN_FREE;
        o_sts.found     = found;
        o_sts.scan_last = scan_last;
        o_sts.rmw_done  = rmw_done;
        o_sts.zero_need = r_need == '0;
        o_sts.out_free  = !r_out_vld || o_rsp.ready;
    end

endmodule

@@ src/bitmap_block_allocator.sv @@
// Top level of the first-fit bitmap block allocator.
// Usage:
//   i_req carries one request: func selects allocate or free, req_size is the
//   byte size for allocate, free_offset the byte offset for free. o_rsp returns
//   exactly one result per request: status, block_offset, block_count,
//   zero_bytes and used_bytes. i_cfg writes max_request_bytes (index 0),
//   zero_depth (index 1) and shallow_zero_bytes (index 2); the user must do so
//   only while no request is in flight, which the block does not enforce.
//   i_cfg is always ready. Requests are handled one at a time. A request
//   rejected at once (size too large, invalid pointer) goes straight from
//   its start to the result. Any other allocate scans one bitmap word per cycle
//   (up to 8) and then marks the words it needs, each updated by a read and a
//   write through the single read and single write port of the bitmap memory.
//   Any other free clears words the same way, a read and then a write per word.
//   The next request is accepted the cycle after the result is registered.
//   Reset empties the pool, clears the byte counter and loads the default
//   configuration. A stalled receiver holds the result in the output register;
//   one more request can be taken and worked on, and then waits for that slot.
`timescale 1ns / 1ps

module bitmap_block_allocator import bba_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_req_if.sink   i_req,
    bba_cfg_if.sink   i_cfg,
    bba_rsp_if.source o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    bba_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp)
    );

endmodule
